### rtl/hdlcrx_pkg.sv
// Shared types, constants and the FCS-16 byte update for the HDLC frame receiver.
`timescale 1ns / 1ps

package hdlcrx_pkg;

    localparam int ByteW     = 8;
    localparam int StatusW   = 2;
    localparam int FrameLenW = 7;
    localparam int FcsW      = 16;
    localparam int ApbAddrW  = 5;
    localparam int ApbDataW  = 32;

    localparam logic [FcsW-1:0]  FcsPreset = 16'hFFFF;
    localparam logic [FcsW-1:0]  FcsGood   = 16'hF0B8;
    localparam logic [FcsW-1:0]  FcsPoly   = 16'h8408;
    localparam logic [ByteW-1:0] EscXor    = 8'h20;
    localparam logic [ByteW-1:0] RespBit   = 8'h80;
    localparam int MinFrame   = 5;
    localparam int HeaderBytes = 4;

    localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
    localparam logic [StatusW-1:0] STATUS_FCS_ERR  = 2'd1;
    localparam logic [StatusW-1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [2:0] REG_FLAG     = 3'd0;
    localparam logic [2:0] REG_ESCAPE   = 3'd1;
    localparam logic [2:0] REG_ADDRESS  = 3'd2;
    localparam logic [2:0] REG_PROTOCOL = 3'd3;
    localparam logic [2:0] REG_LAST_REQ = 3'd4;

    typedef struct packed {
        logic [ByteW-1:0] flag_byte;
        logic [ByteW-1:0] escape_byte;
        logic [ByteW-1:0] station_address;
        logic [ByteW-1:0] protocol_number;
        logic [ByteW-1:0] last_request_code;
    } cfg_t;

    typedef struct packed {
        logic [StatusW-1:0]   frame_status;
        logic [ByteW-1:0]     msg_code;
        logic [ByteW-1:0]     ack_value;
        logic [FrameLenW-1:0] frame_length;
        logic                 response_match;
    } result_t;

    function automatic logic [FcsW-1:0] fcs16_byte(input logic [FcsW-1:0] fcs,
                                                   input logic [ByteW-1:0] b);
        logic [FcsW-1:0] c;
        c = fcs ^ {{(FcsW-ByteW){1'b0}}, b};
        for (int i = 0; i < ByteW; i++) begin
            c = c[0] ? ((c >> 1) ^ FcsPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/hdlcrx_core.sv
// Deframing state machine: unescaping, FCS-16, header capture and frame status.
`timescale 1ns / 1ps

module hdlcrx_core #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [hdlcrx_pkg::ByteW-1:0]  rx_byte,
    input  hdlcrx_pkg::cfg_t              cfg,
    output logic                          res_valid,
    output hdlcrx_pkg::result_t           res
);

    localparam int MaxStored = MAX_PAYLOAD + hdlcrx_pkg::HeaderBytes;
    localparam int CountW    = $clog2(MaxStored + 1);

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;

    logic [1:0]                       mode_reg, mode_next;
    logic [CountW-1:0]                count_reg, count_next;
    logic [hdlcrx_pkg::FcsW-1:0]      fcs_reg, fcs_next;
    logic [hdlcrx_pkg::ByteW-1:0]     addr_reg, addr_next;
    logic [hdlcrx_pkg::ByteW-1:0]     proto_reg, proto_next;
    logic [hdlcrx_pkg::ByteW-1:0]     code_reg, code_next;
    logic [hdlcrx_pkg::ByteW-1:0]     ack_reg, ack_next;

    logic                             is_flag;
    logic                             do_store;
    logic [hdlcrx_pkg::ByteW-1:0]     store_val;

    assign is_flag = (rx_byte == cfg.flag_byte);

    always_comb begin
        do_store  = 1'b0;
        store_val = rx_byte;
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_HUNT: begin
                mode_next = MODE_HUNT;
            end
            MODE_DATA: begin
                if (rx_byte == cfg.escape_byte) begin
                    mode_next = MODE_ESC;
                end else begin
                    do_store = 1'b1;
                end
            end
            MODE_ESC: begin
                do_store  = 1'b1;
                store_val = rx_byte ^ hdlcrx_pkg::EscXor;
            end
            default: begin
                mode_next = MODE_HUNT;
            end
        endcase

        count_next = count_reg;
        fcs_next   = fcs_reg;
        addr_next  = addr_reg;
        proto_next = proto_reg;
        code_next  = code_reg;
        ack_next   = ack_reg;

        if (is_flag) begin
            count_next = '0;
            fcs_next   = hdlcrx_pkg::FcsPreset;
            mode_next  = MODE_DATA;
        end else if (do_store) begin
            if (count_reg < CountW'(MaxStored)) begin
                if (count_reg == CountW'(0)) addr_next  = store_val;
                if (count_reg == CountW'(1)) proto_next = store_val;
                if (count_reg == CountW'(2)) code_next  = store_val;
                if (count_reg == CountW'(3)) ack_next   = store_val;
                fcs_next   = hdlcrx_pkg::fcs16_byte(fcs_reg, store_val);
                count_next = count_reg + CountW'(1);
                mode_next  = MODE_DATA;
            end else begin
                count_next = '0;
                mode_next  = MODE_HUNT;
            end
        end
    end

    always_comb begin
        res_valid          = step && is_flag && (count_reg >= CountW'(hdlcrx_pkg::MinFrame));
        res.msg_code       = code_reg;
        res.ack_value      = ack_reg;
        res.frame_length   = hdlcrx_pkg::FrameLenW'(count_reg);
        res.response_match = 1'b0;
        if (fcs_reg != hdlcrx_pkg::FcsGood) begin
            res.frame_status = hdlcrx_pkg::STATUS_FCS_ERR;
        end else if (addr_reg != cfg.station_address || proto_reg != cfg.protocol_number) begin
            res.frame_status = hdlcrx_pkg::STATUS_MISMATCH;
        end else begin
            res.frame_status   = hdlcrx_pkg::STATUS_OK;
            res.response_match = ((cfg.last_request_code | hdlcrx_pkg::RespBit) == code_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_HUNT;
            count_reg <= '0;
            fcs_reg   <= hdlcrx_pkg::FcsPreset;
            addr_reg  <= '0;
            proto_reg <= '0;
            code_reg  <= '0;
            ack_reg   <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            fcs_reg   <= fcs_next;
            addr_reg  <= addr_next;
            proto_reg <= proto_next;
            code_reg  <= code_next;
            ack_reg   <= ack_next;
        end
    end

    a_result_only_on_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (step && rx_byte == cfg.flag_byte))
        else $error("Frame status produced without a flag word.");

    a_flag_restarts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && is_flag) |=> (count_reg == '0 && fcs_reg == hdlcrx_pkg::FcsPreset
                               && mode_reg == MODE_DATA))
        else $error("Flag word did not restart the frame.");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountW'(MaxStored))
        else $error("Stored byte count exceeds the frame limit.");

endmodule

### rtl/hdlc_frame_receiver_fcs16_top.sv
// Top level of the HDLC frame receiver: APB registers, input stage and result register.
`timescale 1ns / 1ps

// The receiver takes one raw line word per cycle and returns one status word for each
// closed frame of at least five stored bytes. A word passes an input register, then
// unescaping, the byte-wide FCS-16 update and the header compare in one stage, and
// the status of a frame lands in the result register as its flag word leaves the input
// register. Sustained rate is one word per cycle, set by the single-stage FCS update;
// the input stalls only while a finished status waits for m_ready.

module hdlc_frame_receiver_fcs16_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hdlcrx_pkg::ApbAddrW-1:0]      paddr,
    input  logic [hdlcrx_pkg::ApbDataW-1:0]      pwdata,
    output logic [hdlcrx_pkg::ApbDataW-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [hdlcrx_pkg::ByteW-1:0]         s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [hdlcrx_pkg::StatusW-1:0]       m_frame_status,
    output logic [hdlcrx_pkg::ByteW-1:0]         m_msg_code,
    output logic [hdlcrx_pkg::ByteW-1:0]         m_ack_value,
    output logic [hdlcrx_pkg::FrameLenW-1:0]     m_frame_length,
    output logic                                 m_response_match
);

    hdlcrx_pkg::cfg_t                 cfg_reg;
    logic [2:0]                       reg_index;
    logic                             cfg_write;

    logic                             in_valid_reg, in_valid_next;
    logic [hdlcrx_pkg::ByteW-1:0]     in_byte_reg;
    logic                             out_valid_reg, out_valid_next;
    hdlcrx_pkg::result_t              out_reg;

    logic                             advance;
    logic                             res_valid;
    hdlcrx_pkg::result_t              res;

    assign pready    = 1'b1;
    assign reg_index = paddr[hdlcrx_pkg::ApbAddrW-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte         <= 8'h7E;
            cfg_reg.escape_byte       <= 8'h7D;
            cfg_reg.station_address   <= 8'hFF;
            cfg_reg.protocol_number   <= 8'h00;
            cfg_reg.last_request_code <= 8'h00;
        end else if (cfg_write) begin
            unique case (reg_index)
                hdlcrx_pkg::REG_FLAG:     cfg_reg.flag_byte       <= pwdata[7:0];
                hdlcrx_pkg::REG_ESCAPE:   cfg_reg.escape_byte     <= pwdata[7:0];
                hdlcrx_pkg::REG_ADDRESS:  cfg_reg.station_address <= pwdata[7:0];
                hdlcrx_pkg::REG_PROTOCOL: cfg_reg.protocol_number <= pwdata[7:0];
                hdlcrx_pkg::REG_LAST_REQ: cfg_reg.last_request_code <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            hdlcrx_pkg::REG_FLAG:     prdata[7:0] = cfg_reg.flag_byte;
            hdlcrx_pkg::REG_ESCAPE:   prdata[7:0] = cfg_reg.escape_byte;
            hdlcrx_pkg::REG_ADDRESS:  prdata[7:0] = cfg_reg.station_address;
            hdlcrx_pkg::REG_PROTOCOL: prdata[7:0] = cfg_reg.protocol_number;
            hdlcrx_pkg::REG_LAST_REQ: prdata[7:0] = cfg_reg.last_request_code;
            default: prdata = '0;
        endcase
    end

    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance ? res_valid : (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    hdlcrx_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_valid          = out_valid_reg;
    assign m_frame_status   = out_reg.frame_status;
    assign m_msg_code       = out_reg.msg_code;
    assign m_ack_value      = out_reg.ack_value;
    assign m_frame_length   = out_reg.frame_length;
    assign m_response_match = out_reg.response_match;

    a_held_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("Waiting input word was lost or changed.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("Result register overwritten before it was taken.");

endmodule

### dv/hdlc_frame_receiver_fcs16_top_tb.sv
// Self-checking testbench for the HDLC frame receiver with FCS-16 status reporting.
`timescale 1ns / 1ps

module hdlc_frame_receiver_fcs16_top_tb;

    localparam int MaxPayload    = 64;
    localparam int MaxStored     = MaxPayload + hdlcrx_pkg::HeaderBytes;
    localparam int NumDir        = 29;
    localparam int NumPhases     = 6;
    localparam int PhaseWords    = 230;
    localparam int DrainCycles   = 8;
    localparam int WatchdogLimit = 1000;

    typedef enum logic [1:0] {LINE_HUNT, LINE_DATA, LINE_ESC} line_mode_t;

    typedef struct packed {
        logic [hdlcrx_pkg::ByteW-1:0] rx;
        logic                         typed;
        hdlcrx_pkg::result_t          want;
    } line_row_t;

    localparam line_row_t DirRows [NumDir] = '{
        '{8'h11, 1'b0, '0}, '{8'h7E, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'h7D, 1'b0, '0}, '{8'h7E, 1'b0, '0},
        '{8'h7D, 1'b0, '0}, '{8'h11, 1'b0, '0}, '{8'h32, 1'b0, '0}, '{8'h33, 1'b0, '0},
        '{8'h34, 1'b0, '0}, '{8'h35, 1'b0, '0}, '{8'h36, 1'b0, '0}, '{8'h37, 1'b0, '0},
        '{8'h38, 1'b0, '0}, '{8'h39, 1'b0, '0},
        '{8'h7E, 1'b1, hdlcrx_pkg::result_t'{hdlcrx_pkg::STATUS_FCS_ERR,
                                             8'h33, 8'h34, 7'd9, 1'b0}},
        '{8'h31, 1'b0, '0}, '{8'h32, 1'b0, '0}, '{8'h33, 1'b0, '0}, '{8'h34, 1'b0, '0},
        '{8'h35, 1'b0, '0}, '{8'h36, 1'b0, '0}, '{8'h37, 1'b0, '0}, '{8'h38, 1'b0, '0},
        '{8'h39, 1'b0, '0}, '{8'h6E, 1'b0, '0}, '{8'h90, 1'b0, '0},
        '{8'h7E, 1'b1, hdlcrx_pkg::result_t'{hdlcrx_pkg::STATUS_MISMATCH,
                                             8'h33, 8'h34, 7'd11, 1'b0}}
    };

    localparam hdlcrx_pkg::cfg_t FixedSettings [4] = '{
        hdlcrx_pkg::cfg_t'{8'h7E, 8'h7D, 8'hFF, 8'h00, 8'h05},
        hdlcrx_pkg::cfg_t'{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF},
        hdlcrx_pkg::cfg_t'{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00},
        hdlcrx_pkg::cfg_t'{8'h55, 8'h55, 8'h12, 8'h34, 8'h7F}
    };

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [hdlcrx_pkg::ApbAddrW-1:0]      paddr = '0;
    logic [hdlcrx_pkg::ApbDataW-1:0]      pwdata = '0;
    logic [hdlcrx_pkg::ApbDataW-1:0]      prdata;
    logic                                 pready;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [hdlcrx_pkg::ByteW-1:0]         s_rx_byte = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [hdlcrx_pkg::StatusW-1:0]       m_frame_status;
    logic [hdlcrx_pkg::ByteW-1:0]         m_msg_code;
    logic [hdlcrx_pkg::ByteW-1:0]         m_ack_value;
    logic [hdlcrx_pkg::FrameLenW-1:0]     m_frame_length;
    logic                                 m_response_match;

    hdlcrx_pkg::cfg_t             cfg = hdlcrx_pkg::cfg_t'{8'h7E, 8'h7D, 8'hFF, 8'h00, 8'h00};
    line_mode_t                   line_mode = LINE_HUNT;
    int                           stored_count = 0;
    logic [hdlcrx_pkg::FcsW-1:0]  fcs_acc = hdlcrx_pkg::FcsPreset;
    logic [hdlcrx_pkg::ByteW-1:0] hdr_addr = '0;
    logic [hdlcrx_pkg::ByteW-1:0] hdr_proto = '0;
    logic [hdlcrx_pkg::ByteW-1:0] hdr_code = '0;
    logic [hdlcrx_pkg::ByteW-1:0] hdr_ack = '0;

    hdlcrx_pkg::result_t pending_status [$];
    hdlcrx_pkg::result_t status_head;
    logic    steady = 1'b0;
    int      quiet_cycles = 0;
    int      mismatches = 0;
    int      words_sent = 0;
    int      status_checked = 0;
    int      n_ok = 0;
    int      n_fcs = 0;
    int      n_addr = 0;
    int      n_match = 0;

    hdlc_frame_receiver_fcs16_top #(
        .MAX_PAYLOAD(MaxPayload)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_status  (m_frame_status),
        .m_msg_code      (m_msg_code),
        .m_ack_value     (m_ack_value),
        .m_frame_length  (m_frame_length),
        .m_response_match(m_response_match)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [hdlcrx_pkg::FcsW-1:0] fcs_next(
        input logic [hdlcrx_pkg::FcsW-1:0] c,
        input logic [hdlcrx_pkg::ByteW-1:0] b);
        logic fb;
        for (int i = 0; i < hdlcrx_pkg::ByteW; i++) begin
            fb = c[0] ^ b[i];
            c = {1'b0, c[hdlcrx_pkg::FcsW-1:1]} ^ (fb ? hdlcrx_pkg::FcsPoly : '0);
        end
        return c;
    endfunction

    task automatic deframe_byte(input logic [hdlcrx_pkg::ByteW-1:0] b, output logic got,
                                output hdlcrx_pkg::result_t r);
        logic [hdlcrx_pkg::ByteW-1:0] v;
        got = 1'b0;
        r = '0;
        if (b == cfg.flag_byte) begin
            if (stored_count >= hdlcrx_pkg::MinFrame) begin
                got = 1'b1;
                if (fcs_acc != hdlcrx_pkg::FcsGood) begin
                    r.frame_status = hdlcrx_pkg::STATUS_FCS_ERR;
                end else if (hdr_addr != cfg.station_address
                             || hdr_proto != cfg.protocol_number) begin
                    r.frame_status = hdlcrx_pkg::STATUS_MISMATCH;
                end else begin
                    r.frame_status = hdlcrx_pkg::STATUS_OK;
                end
                r.msg_code = hdr_code;
                r.ack_value = hdr_ack;
                r.frame_length = hdlcrx_pkg::FrameLenW'(stored_count);
                r.response_match = (r.frame_status == hdlcrx_pkg::STATUS_OK)
                                   && (hdr_code == (cfg.last_request_code
                                                    | hdlcrx_pkg::RespBit));
            end
            stored_count = 0;
            fcs_acc = hdlcrx_pkg::FcsPreset;
            line_mode = LINE_DATA;
        end else if (line_mode == LINE_DATA && b == cfg.escape_byte) begin
            line_mode = LINE_ESC;
        end else if (line_mode != LINE_HUNT) begin
            v = (line_mode == LINE_ESC) ? (b ^ hdlcrx_pkg::EscXor) : b;
            if (stored_count < MaxStored) begin
                case (stored_count)
                    0: hdr_addr = v;
                    1: hdr_proto = v;
                    2: hdr_code = v;
                    3: hdr_ack = v;
                    default: ;
                endcase
                fcs_acc = fcs_next(fcs_acc, v);
                stored_count++;
                line_mode = LINE_DATA;
            end else begin
                line_mode = LINE_HUNT;
                stored_count = 0;
            end
        end
    endtask

    task automatic send_byte(input logic [hdlcrx_pkg::ByteW-1:0] b, input logic typed,
                             input hdlcrx_pkg::result_t typed_res);
        logic                hit;
        logic                got;
        hdlcrx_pkg::result_t res;
        if (!steady && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do begin
            @(negedge aclk);
            hit = s_ready;
            @(posedge aclk);
        end while (!hit);
        words_sent++;
        deframe_byte(b, got, res);
        if (got) begin
            pending_status.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [hdlcrx_pkg::ByteW-1:0] v);
        logic hit;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= hdlcrx_pkg::ApbDataW'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            hit = pready;
            @(posedge aclk);
        end while (!hit);
        case (idx)
            hdlcrx_pkg::REG_FLAG:     cfg.flag_byte = v;
            hdlcrx_pkg::REG_ESCAPE:   cfg.escape_byte = v;
            hdlcrx_pkg::REG_ADDRESS:  cfg.station_address = v;
            hdlcrx_pkg::REG_PROTOCOL: cfg.protocol_number = v;
            hdlcrx_pkg::REG_LAST_REQ: cfg.last_request_code = v;
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [hdlcrx_pkg::ByteW-1:0] want,
                               input logic [hdlcrx_pkg::ByteW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 17);
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: status word with none expected, status %0d length %0d",
                         $time, m_frame_status, m_frame_length);
                mismatches++;
            end else begin
                status_head = pending_status.pop_front();
                check_field("frame_status",
                            hdlcrx_pkg::ByteW'(status_head.frame_status),
                            hdlcrx_pkg::ByteW'(m_frame_status));
                check_field("msg_code", status_head.msg_code, m_msg_code);
                check_field("ack_value", status_head.ack_value, m_ack_value);
                check_field("frame_length",
                            hdlcrx_pkg::ByteW'(status_head.frame_length),
                            hdlcrx_pkg::ByteW'(m_frame_length));
                check_field("response_match",
                            hdlcrx_pkg::ByteW'(status_head.response_match),
                            hdlcrx_pkg::ByteW'(m_response_match));
                status_checked++;
                n_ok += int'(status_head.frame_status == hdlcrx_pkg::STATUS_OK);
                n_fcs += int'(status_head.frame_status == hdlcrx_pkg::STATUS_FCS_ERR);
                n_addr += int'(status_head.frame_status == hdlcrx_pkg::STATUS_MISMATCH);
                n_match += int'(status_head.response_match);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        hdlcrx_pkg::cfg_t             next_cfg;
        logic [hdlcrx_pkg::ByteW-1:0] frame [$];
        logic [hdlcrx_pkg::FcsW-1:0]  crc;
        logic                         raw;
        int                           kind;
        int                           n;
        int                           phase_end;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < NumDir; i++) begin
            send_byte(DirRows[i].rx, DirRows[i].typed, DirRows[i].want);
        end
        for (int p = 0; p < NumPhases; p++) begin
            drain_pipeline();
            if (p < 4) begin
                next_cfg = FixedSettings[p];
            end else begin
                next_cfg = hdlcrx_pkg::cfg_t'(40'({$urandom(), $urandom()}));
            end
            apb_write(hdlcrx_pkg::REG_FLAG, next_cfg.flag_byte);
            apb_write(hdlcrx_pkg::REG_ESCAPE, next_cfg.escape_byte);
            apb_write(hdlcrx_pkg::REG_ADDRESS, next_cfg.station_address);
            apb_write(hdlcrx_pkg::REG_PROTOCOL, next_cfg.protocol_number);
            apb_write(hdlcrx_pkg::REG_LAST_REQ, next_cfg.last_request_code);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(posedge aclk);
            steady = (p == NumPhases - 1);
            phase_end = words_sent + PhaseWords;
            while (words_sent < phase_end) begin
                kind = $urandom_range(99);
                raw = 1'b0;
                frame.delete();
                if (kind < 70) begin
                    n = $urandom_range(39);
                    n = (n == 0) ? MaxStored - 2 :
                        (n < 3) ? $urandom_range(MaxStored - 3, 12) : $urandom_range(11, 3);
                    frame.push_back($urandom_range(9) == 0 ? 8'($urandom())
                                                           : cfg.station_address);
                    frame.push_back($urandom_range(9) == 0 ? 8'($urandom())
                                                           : cfg.protocol_number);
                    frame.push_back($urandom_range(2) == 0
                                    ? (cfg.last_request_code | hdlcrx_pkg::RespBit)
                                    : 8'($urandom()));
                    while (frame.size() < n) frame.push_back(8'($urandom()));
                    crc = hdlcrx_pkg::FcsPreset;
                    foreach (frame[i]) crc = fcs_next(crc, frame[i]);
                    crc = ~crc;
                    frame.push_back(crc[7:0]);
                    frame.push_back(crc[15:8]);
                    if ($urandom_range(3) == 0) begin
                        send_byte(cfg.flag_byte, 1'b0, '0);
                    end
                end else begin
                    raw = (kind >= 94);
                    n = (kind < 82) ? $urandom_range(10, 5) :
                        (kind < 88) ? $urandom_range(4, 0) :
                        (kind < 94) ? $urandom_range(MaxStored + 4, MaxStored + 1) :
                                      $urandom_range(12, 1);
                    repeat (n) begin
                        frame.push_back((raw && $urandom_range(7) == 0) ? cfg.flag_byte
                                                                        : 8'($urandom()));
                    end
                end
                foreach (frame[i]) begin
                    if (!raw && cfg.escape_byte != cfg.flag_byte
                        && (frame[i] == cfg.flag_byte || frame[i] == cfg.escape_byte
                            || $urandom_range(9) == 0)) begin
                        send_byte(cfg.escape_byte, 1'b0, '0);
                        send_byte(frame[i] ^ hdlcrx_pkg::EscXor, 1'b0, '0);
                    end else begin
                        send_byte(frame[i], 1'b0, '0);
                    end
                end
                send_byte(cfg.flag_byte, 1'b0, '0);
            end
        end
        drain_pipeline();
        $display("Sent %0d line words under %0d register settings, idling on both sides",
                 words_sent, NumPhases + 1);
        $display("Checked %0d status words: %0d accepted (%0d responses), %0d FCS, %0d addr",
                 status_checked, n_ok, n_match, n_fcs, n_addr);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/hdlcrx_pkg.sv
rtl/hdlcrx_core.sv
rtl/hdlc_frame_receiver_fcs16_top.sv
dv/hdlc_frame_receiver_fcs16_top_tb.sv
